// File: hw/rtl/bbc_pkg.sv
// Shared types, character codes and helpers for the bracket balance checker.
`default_nettype none

package bbc_pkg;

	// Payload widths of the stream channels
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned LINE_W   = 20;
	localparam int unsigned CHAR_W   = 7;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NEWLINE     = 8'd10;
	localparam logic [BYTE_W-1:0] CH_PAREN_OPEN  = 8'h28;
	localparam logic [BYTE_W-1:0] CH_PAREN_CLOSE = 8'h29;
	localparam logic [BYTE_W-1:0] CH_SQ_OPEN     = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_SQ_CLOSE    = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_CURLY_OPEN  = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_CURLY_CLOSE = 8'h7D;

	// Bracket kind as held on the stack
	typedef enum logic [1:0] {
		KIND_PAREN  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	// Verdict codes
	typedef enum logic [STATUS_W-1:0] {
		ST_BALANCED = 3'd0,
		ST_NO_OPENER = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_UNCLOSED = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// Closing character of a kind
	function automatic logic [CHAR_W-1:0] closer_of(input kind_t kind);
		logic [BYTE_W-1:0] ch;
		case (kind)
			KIND_PAREN:  ch = CH_PAREN_CLOSE;
			KIND_SQUARE: ch = CH_SQ_CLOSE;
			default:     ch = CH_CURLY_CLOSE;
		endcase
		return ch[CHAR_W-1:0];
	endfunction

	// Opening character of a kind
	function automatic logic [CHAR_W-1:0] opener_of(input kind_t kind);
		logic [BYTE_W-1:0] ch;
		case (kind)
			KIND_PAREN:  ch = CH_PAREN_OPEN;
			KIND_SQUARE: ch = CH_SQ_OPEN;
			default:     ch = CH_CURLY_OPEN;
		endcase
		return ch[CHAR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bbc_in_if.sv
// Text byte stream channel: valid/ready plus one byte and its end-of-text mark.
`default_nettype none

interface bbc_in_if;
	import bbc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bbc_out_if.sv
// Verdict channel: valid/ready plus status, line and expected bracket.
`default_nettype none

interface bbc_out_if;
	import bbc_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] check_status;
	logic [LINE_W-1:0]   error_line;
	logic [CHAR_W-1:0]   expected_char;

	modport source (output valid, output check_status, output error_line,
		output expected_char, input ready);
	modport sink (input valid, input check_status, input error_line,
		input expected_char, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bracket_balance_checker_unit.sv
// Bracket balance checker: one text byte per beat in, at most one verdict beat out per byte.
//
// text_in carries one byte per beat with an end-of-text mark on the last byte
// of a text. result_out carries a verdict: balanced, closer without opener,
// mismatched closer, unclosed opener or stack overflow, with a line number
// and the bracket that was expected. A text yields exactly one verdict: the
// first error, or the end-of-text verdict if no error was seen.
// A byte is held in the input register, then checked and its verdict loaded
// into the output register. Throughput: one byte per cycle while result_out
// accepts verdicts, set by the single stack update (one push or pop on one
// memory port) per byte. The top of the stack and the entry below it sit in
// registers, so the next byte never waits on the memory read.
// Reset clears the depth, error flag and line count (line one); the stack
// memory is not cleared. When result_out stalls, bytes that give no verdict
// keep flowing; a byte that gives a verdict waits in the input register.
// End of text clears the checker state for the next text.
`default_nettype none

module bracket_balance_checker_unit #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned LINE_BITS   = 20
) (
	input  wire     clk,
	input  wire     arst_n,
	bbc_in_if.sink    text_in,
	bbc_out_if.source result_out
);
	import bbc_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

	// Input register
	logic              s1_valid;
	logic [BYTE_W-1:0] s1_byte;
	logic              s1_eot;

	// Checker state
	logic [DW-1:0]        depth_q;
	kind_t                top_q;
	kind_t                below_q;
	logic [LINE_BITS-1:0] cur_line_q;
	logic [LINE_BITS-1:0] paren_line_q;
	logic [LINE_BITS-1:0] square_line_q;
	logic [LINE_BITS-1:0] curly_line_q;
	logic                 err_q;

	// Entries under the top of the stack
	kind_t stack_mem [STACK_DEPTH];

	// Result register
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [LINE_W-1:0]   res_line_q;
	logic [CHAR_W-1:0]   res_char_q;

	// Next-state and verdict logic
	logic                 is_open;
	logic                 is_close;
	kind_t                b_kind;
	logic [DW-1:0]        n_depth;
	kind_t                n_top;
	logic [LINE_BITS-1:0] n_cur_line;
	logic [LINE_BITS-1:0] n_paren_line;
	logic [LINE_BITS-1:0] n_square_line;
	logic [LINE_BITS-1:0] n_curly_line;
	logic                 n_err;
	logic                 do_push;
	logic                 hit;
	logic                 produce;
	status_t              v_status;
	logic [LINE_BITS-1:0] v_line;
	logic [CHAR_W-1:0]    v_char;
	logic [DW-1:0]        rd_full;
	logic [DW-1:0]        wr_full;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 out_free;
	logic                 advance;

	// Classify the byte
	always_comb begin
		is_open  = 1'b0;
		is_close = 1'b0;
		b_kind   = KIND_PAREN;
		case (s1_byte)
			CH_PAREN_OPEN:  begin is_open  = 1'b1; b_kind = KIND_PAREN;  end
			CH_SQ_OPEN:     begin is_open  = 1'b1; b_kind = KIND_SQUARE; end
			CH_CURLY_OPEN:  begin is_open  = 1'b1; b_kind = KIND_CURLY;  end
			CH_PAREN_CLOSE: begin is_close = 1'b1; b_kind = KIND_PAREN;  end
			CH_SQ_CLOSE:    begin is_close = 1'b1; b_kind = KIND_SQUARE; end
			CH_CURLY_CLOSE: begin is_close = 1'b1; b_kind = KIND_CURLY;  end
			default:        ;
		endcase
	end

	// Stack step, line tracking and verdict for the held byte
	always_comb begin
		n_depth       = depth_q;
		n_top         = top_q;
		n_cur_line    = cur_line_q;
		n_paren_line  = paren_line_q;
		n_square_line = square_line_q;
		n_curly_line  = curly_line_q;
		do_push       = 1'b0;
		hit           = 1'b0;
		v_status      = ST_BALANCED;
		v_line        = '0;
		v_char        = '0;
		if (!err_q) begin
			if (is_open) begin
				if (depth_q == DEPTH_FULL) begin
					hit      = 1'b1;
					v_status = ST_OVERFLOW;
					v_line   = cur_line_q;
				end else begin
					do_push = 1'b1;
					n_depth = depth_q + DW'(1);
					n_top   = b_kind;
					case (b_kind)
						KIND_PAREN:  n_paren_line  = cur_line_q;
						KIND_SQUARE: n_square_line = cur_line_q;
						default:     n_curly_line  = cur_line_q;
					endcase
				end
			end else if (is_close) begin
				if (depth_q == '0) begin
					hit      = 1'b1;
					v_status = ST_NO_OPENER;
					v_line   = cur_line_q;
					v_char   = opener_of(b_kind);
				end else if (top_q != b_kind) begin
					hit      = 1'b1;
					v_status = ST_MISMATCH;
					v_char   = closer_of(top_q);
					case (top_q)
						KIND_PAREN:  v_line = paren_line_q;
						KIND_SQUARE: v_line = square_line_q;
						default:     v_line = curly_line_q;
					endcase
				end else begin
					n_depth = depth_q - DW'(1);
					n_top   = below_q;
				end
			end else if (s1_byte == CH_NEWLINE && cur_line_q != '1) begin
				n_cur_line = cur_line_q + LINE_BITS'(1);
			end
		end
		n_err   = err_q | hit;
		produce = hit;
		// End-of-text verdict, unless an error was already reported
		if (s1_eot && !n_err) begin
			produce = 1'b1;
			if (n_depth == '0) begin
				v_status = ST_BALANCED;
				v_line   = '0;
				v_char   = '0;
			end else begin
				v_status = ST_UNCLOSED;
				v_char   = closer_of(n_top);
				case (n_top)
					KIND_PAREN:  v_line = n_paren_line;
					KIND_SQUARE: v_line = n_square_line;
					default:     v_line = n_curly_line;
				endcase
			end
		end
	end

	// Memory addresses: old top goes below on push; prefetch entry under new top
	assign wr_full = depth_q - DW'(1);
	assign rd_full = n_depth - DW'(2);
	assign wr_addr = wr_full[AW-1:0];
	assign rd_addr = rd_full[AW-1:0];

	// Handshake
	assign out_free      = !res_valid_q || result_out.ready;
	assign advance       = s1_valid && (!produce || out_free);
	assign text_in.ready = !s1_valid || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (text_in.ready) begin
			s1_valid <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			s1_byte <= text_in.text_byte;
			s1_eot  <= text_in.end_of_text;
		end
	end

	// Checker state; end of text starts a fresh text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q       <= '0;
			top_q         <= KIND_PAREN;
			cur_line_q    <= LINE_BITS'(1);
			paren_line_q  <= '0;
			square_line_q <= '0;
			curly_line_q  <= '0;
			err_q         <= 1'b0;
		end else if (advance) begin
			if (s1_eot) begin
				depth_q       <= '0;
				top_q         <= KIND_PAREN;
				cur_line_q    <= LINE_BITS'(1);
				paren_line_q  <= '0;
				square_line_q <= '0;
				curly_line_q  <= '0;
				err_q         <= 1'b0;
			end else begin
				depth_q       <= n_depth;
				top_q         <= n_top;
				cur_line_q    <= n_cur_line;
				paren_line_q  <= n_paren_line;
				square_line_q <= n_square_line;
				curly_line_q  <= n_curly_line;
				err_q         <= n_err;
			end
		end
	end

	// Stack memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (advance && do_push && depth_q != '0) begin
			stack_mem[wr_addr] <= top_q;
		end
		if (advance) begin
			below_q <= do_push ? top_q : stack_mem[rd_addr];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_status_q <= v_status;
			res_line_q   <= LINE_W'(v_line);
			res_char_q   <= v_char;
		end
	end

	assign result_out.valid         = res_valid_q;
	assign result_out.check_status  = res_status_q;
	assign result_out.error_line    = res_line_q;
	assign result_out.expected_char = res_char_q;

`ifndef SYNTHESIS
	// Depth never runs past the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_FULL)
		else $error("stack depth beyond capacity");

	// End of text leaves a cleared checker
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_eot |=> depth_q == '0 && !err_q && cur_line_q == LINE_BITS'(1))
		else $error("end of text did not clear state");

	// Once an error is reported, no further verdict until end of text
	a_quiet_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && err_q && !s1_eot |-> !produce)
		else $error("verdict issued after an error");

	// A push grows the stack by exactly one
	a_push_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_push && !s1_eot |=> depth_q == $past(depth_q) + DW'(1))
		else $error("push did not grow the stack by one");

	// Line count never reaches zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_line_q != '0)
		else $error("line counter wrapped to zero");
`endif

endmodule

`default_nettype wire
